// ===== src/hsg_pkg.sv =====
// Shared types and constants for the hop sequence generator.
`default_nettype none

package hsg_pkg;

   localparam int CH_W   = 8;
   localparam int HOP_W  = 16;
   localparam int FREQ_W = 32;
   localparam int UID_W  = 32;
   localparam int LCG_W  = 31;
   localparam int TA_W   = 8;
   localparam int J_W    = 9;

   localparam logic [LCG_W-1:0]  LCG_MUL   = 31'd214013;
   localparam logic [LCG_W-1:0]  LCG_ADD   = 31'd2531011;
   localparam logic [FREQ_W-1:0] FREQ_BASE = 32'd2400400000;
   localparam logic [FREQ_W-1:0] FREQ_STEP = 32'd1000000;
   localparam logic [7:0]        SEED_XOR  = 8'd3;

   typedef enum logic [1:0] {
      CMD_REGEN  = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_FREQ   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic {
      MOD_SEQ  = 1'b0,
      MOD_CHAN = 1'b1
   } mod_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_SH_STEP,
      ST_SH_DRAW,
      ST_SH_WAIT,
      ST_SH_READ,
      ST_SH_WR_I,
      ST_SH_WR_J,
      ST_LK_WAIT,
      ST_LK_READ,
      ST_LK_DATA,
      ST_F_MUL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic            re;
      logic [TA_W-1:0] raddr_a;
      logic [TA_W-1:0] raddr_b;
      logic            we;
      logic [TA_W-1:0] waddr;
      logic [CH_W-1:0] wdata;
   } tbl_req_type;

   typedef struct packed {
      logic              load;
      cmd_type           kind;
      logic [CH_W-1:0]   channel;
      logic [FREQ_W-1:0] freq;
   } rsp_load_type;

endpackage

`default_nettype wire

// ===== src/hsg_table.sv =====
// Hop table memory: one write port, two registered read ports.
`default_nettype none

module hsg_table
   import hsg_pkg::*;
#(
   parameter int DEPTH = 240
) (
   input  wire logic        clock,
   input  wire tbl_req_type req,
   output logic [CH_W-1:0]  rd_a,
   output logic [CH_W-1:0]  rd_b
);

   localparam int AW = $clog2(DEPTH);

   logic [CH_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr[AW-1:0]] <= req.wdata;
      end
      if (req.re) begin
         rd_a <= mem[req.raddr_a[AW-1:0]];
         rd_b <= mem[req.raddr_b[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

// ===== src/hsg_modu.sv =====
// Two-stage modulo unit by reciprocal multiply for two constant divisors.
`default_nettype none

module hsg_modu
   import hsg_pkg::*;
#(
   parameter int DIV_A = 240,
   parameter int DIV_B = 79
) (
   input  wire logic             clock,
   input  wire logic [HOP_W-1:0] value,
   input  wire mod_sel_type      sel,
   output logic [CH_W-1:0]       rem
);

   localparam logic [31:0]     RECIP_A = 32'(64'h1_0000_0000 / DIV_A);
   localparam logic [31:0]     RECIP_B = 32'(64'h1_0000_0000 / DIV_B);
   localparam logic [CH_W-1:0] D_A     = CH_W'(DIV_A);
   localparam logic [CH_W-1:0] D_B     = CH_W'(DIV_B);

   logic [47:0]      prod_ff, prod_in;
   logic [HOP_W-1:0] val_ff;
   logic [CH_W-1:0]  div_ff, div_in;
   logic [CH_W-1:0]  rem_ff, rem_in;
   logic [31:0]      recip;
   logic [HOP_W-1:0] quot;
   logic [HOP_W-1:0] raw;

   always_comb begin
      unique case (sel)
         MOD_SEQ: begin
            recip  = RECIP_A;
            div_in = D_A;
         end
         MOD_CHAN: begin
            recip  = RECIP_B;
            div_in = D_B;
         end
         default: begin
            recip  = RECIP_A;
            div_in = D_A;
         end
      endcase
      prod_in = 48'(value) * 48'(recip);
   end

   always_comb begin
      quot = prod_ff[47:32];
      raw  = val_ff - HOP_W'(quot * HOP_W'(div_ff));
      if (raw >= HOP_W'(div_ff)) begin
         rem_in = CH_W'(raw - HOP_W'(div_ff));
      end else begin
         rem_in = CH_W'(raw);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      val_ff  <= value;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

   assign rem = rem_ff;

endmodule

`default_nettype wire

// ===== src/hsg_ctrl.sv =====
// Sequencer for table fill, shuffle, lookup and frequency conversion.
`default_nettype none

module hsg_ctrl
   import hsg_pkg::*;
#(
   parameter int CHANNELS = 80,
   parameter int SEQ_LEN  = 240
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_command,
   input  wire logic [HOP_W-1:0] req_hop_index,
   input  wire logic [CH_W-1:0]  req_channel_index,
   output logic                  req_stall,
   input  wire logic [UID_W-1:0] uid_word,
   input  wire logic             out_free,
   input  wire logic [CH_W-1:0]  rem,
   output logic [HOP_W-1:0]      mod_value,
   output mod_sel_type           mod_sel,
   input  wire logic [CH_W-1:0]  rd_a,
   input  wire logic [CH_W-1:0]  rd_b,
   output tbl_req_type           tbl_req,
   output rsp_load_type          rsp_ld
);

   localparam int              PW     = $clog2(CHANNELS);
   localparam int              SYNC   = CHANNELS / 2 + 1;
   localparam logic [PW-1:0]   POS_LAST = PW'(CHANNELS - 1);
   localparam logic [PW-1:0]   POS_SYNC = PW'(SYNC);
   localparam logic [TA_W-1:0] I_LAST = TA_W'(SEQ_LEN - 1);
   localparam logic [J_W-1:0]  J_END  = J_W'(SEQ_LEN);

   state_type          state_ff, state_in;
   logic [TA_W-1:0]    i_ff, i_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [TA_W-1:0]    base_ff, base_in;
   logic [LCG_W-1:0]   lcg_ff, lcg_in;
   logic               gen_ff, gen_in;
   cmd_type            kind_ff, kind_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic [J_W-1:0]     j_ff, j_in;
   logic [FREQ_W-1:0]  fprod_ff, fprod_in;

   logic               accept;
   cmd_type            cmd;
   logic               last_i;
   logic               pos_zero;
   logic [J_W-1:0]     j_calc;
   logic               j_ok;
   logic               adv;
   logic [CH_W-1:0]    fill_val;

   assign accept   = req_valid && !req_stall;
   assign cmd      = cmd_type'(req_command);
   assign last_i   = (i_ff == I_LAST);
   assign pos_zero = (pos_ff == '0);
   assign j_calc   = J_W'(base_ff) + J_W'(rem) + J_W'(1);
   assign j_ok     = (j_calc < J_END);

   always_comb begin
      if (pos_zero) begin
         fill_val = CH_W'(SYNC);
      end else if (pos_ff == POS_SYNC) begin
         fill_val = '0;
      end else begin
         fill_val = CH_W'(pos_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_REGEN:  state_in = ST_FILL;
                  CMD_LOOKUP: state_in = ST_LK_WAIT;
                  CMD_FREQ:   state_in = ST_F_MUL;
                  CMD_NONE:   state_in = ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL:    state_in = last_i ? ST_SH_STEP : ST_FILL;
         ST_SH_STEP: begin
            if (!pos_zero) begin
               state_in = ST_SH_DRAW;
            end else begin
               state_in = last_i ? ST_RESP : ST_SH_STEP;
            end
         end
         ST_SH_DRAW: state_in = ST_SH_WAIT;
         ST_SH_WAIT: state_in = ST_SH_READ;
         ST_SH_READ: begin
            if (j_ok) begin
               state_in = ST_SH_WR_I;
            end else begin
               state_in = last_i ? ST_RESP : ST_SH_STEP;
            end
         end
         ST_SH_WR_I: state_in = ST_SH_WR_J;
         ST_SH_WR_J: state_in = last_i ? ST_RESP : ST_SH_STEP;
         ST_LK_WAIT: state_in = ST_LK_READ;
         ST_LK_READ: state_in = ST_LK_DATA;
         ST_LK_DATA: state_in = ST_F_MUL;
         ST_F_MUL:   state_in = ST_RESP;
         ST_RESP:    state_in = out_free ? ST_IDLE : ST_RESP;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      i_in      = i_ff;
      pos_in    = pos_ff;
      base_in   = base_ff;
      lcg_in    = lcg_ff;
      gen_in    = gen_ff;
      kind_in   = kind_ff;
      ch_in     = ch_ff;
      j_in      = j_ff;
      fprod_in  = fprod_ff;
      mod_value = req_hop_index;
      mod_sel   = MOD_SEQ;
      tbl_req   = '0;
      rsp_ld    = '0;
      adv       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = cmd;
               if (cmd == CMD_REGEN) begin
                  lcg_in  = uid_word[LCG_W-1:0] ^ LCG_W'(SEED_XOR);
                  gen_in  = 1'b1;
                  i_in    = '0;
                  pos_in  = '0;
                  base_in = '0;
               end
               if (cmd == CMD_FREQ) begin
                  ch_in = req_channel_index;
               end
            end
         end
         ST_FILL: begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = i_ff;
            tbl_req.wdata = fill_val;
            adv           = 1'b1;
         end
         ST_SH_STEP: begin
            if (pos_zero) begin
               adv = 1'b1;
            end else begin
               lcg_in = lcg_ff * LCG_MUL + LCG_ADD;
            end
         end
         ST_SH_DRAW: begin
            mod_value = HOP_W'(lcg_ff[LCG_W-1:16]);
            mod_sel   = MOD_CHAN;
         end
         ST_SH_WAIT: begin
            mod_sel = MOD_CHAN;
         end
         ST_SH_READ: begin
            j_in = j_calc;
            if (j_ok) begin
               tbl_req.re      = 1'b1;
               tbl_req.raddr_a = i_ff;
               tbl_req.raddr_b = j_calc[TA_W-1:0];
            end else begin
               adv = 1'b1;
            end
         end
         ST_SH_WR_I: begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = i_ff;
            tbl_req.wdata = rd_b;
         end
         ST_SH_WR_J: begin
            tbl_req.we    = 1'b1;
            tbl_req.waddr = j_ff[TA_W-1:0];
            tbl_req.wdata = rd_a;
            adv           = 1'b1;
         end
         ST_LK_WAIT: begin
         end
         ST_LK_READ: begin
            tbl_req.re      = 1'b1;
            tbl_req.raddr_a = rem;
         end
         ST_LK_DATA: begin
            ch_in = gen_ff ? rd_a : '0;
         end
         ST_F_MUL: begin
            fprod_in = FREQ_W'(ch_ff) * FREQ_STEP;
         end
         ST_RESP: begin
            rsp_ld.load = out_free;
            rsp_ld.kind = kind_ff;
            if (kind_ff == CMD_REGEN) begin
               rsp_ld.channel = '0;
               rsp_ld.freq    = '0;
            end else begin
               rsp_ld.channel = ch_ff;
               rsp_ld.freq    = FREQ_BASE + fprod_ff;
            end
         end
         default: begin
         end
      endcase

      if (adv) begin
         if (!last_i) begin
            i_in = i_ff + TA_W'(1);
            if (pos_ff == POS_LAST) begin
               pos_in  = '0;
               base_in = base_ff + TA_W'(CHANNELS);
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end else if (state_ff == ST_FILL) begin
            i_in    = '0;
            pos_in  = '0;
            base_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gen_ff   <= 1'b0;
         lcg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         gen_ff   <= gen_in;
         lcg_ff   <= lcg_in;
      end
      i_ff     <= i_in;
      pos_ff   <= pos_in;
      base_ff  <= base_in;
      kind_ff  <= kind_in;
      ch_ff    <= ch_in;
      j_ff     <= j_in;
      fprod_ff <= fprod_in;
   end

endmodule

`default_nettype wire

// ===== src/hop_sequence_generator.sv =====
// Hop sequence generator: table regeneration, hop lookup and channel-to-frequency conversion.
// No new request is accepted until the controller is back in idle. A lookup (command 1)
// passes through the two-stage modulo unit, the registered table read and the frequency
// multiply; a conversion (command 2) only through the multiply. Regeneration writes the
// SEQ_LEN fill slots, then draws, reads and swaps each slot with a non-zero in-block index
// (no swap when its partner falls past the table end) and steps over each block start,
// then responds and returns to idle, with all writes on the single table write port.
// A stalled result port extends the response state. No clearing pass runs after reset:
// until the first regeneration every lookup returns channel 0. A finished response waits
// in the output register while the next request is taken.
`default_nettype none

module hop_sequence_generator
   import hsg_pkg::*;
#(
   parameter int CHANNELS = 80,
   parameter int SEQ_LEN  = 240
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [1:0]       req_command,
   input  wire logic [HOP_W-1:0] req_hop_index,
   input  wire logic [CH_W-1:0]  req_channel_index,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [CH_W-1:0]       rsp_channel,
   output logic [FREQ_W-1:0]     rsp_freq_hz,
   input  wire logic             csr_we,
   input  wire logic [UID_W-1:0] csr_wdata
);

   logic [UID_W-1:0]  uid_word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff;
   logic [CH_W-1:0]   rsp_channel_ff;
   logic [FREQ_W-1:0] rsp_freq_ff;
   logic              out_free;
   logic [CH_W-1:0]   rem;
   logic [HOP_W-1:0]  mod_value;
   mod_sel_type       mod_sel;
   logic [CH_W-1:0]   rd_a;
   logic [CH_W-1:0]   rd_b;
   tbl_req_type       tbl_req;
   rsp_load_type      rsp_ld;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   hsg_ctrl #(
      .CHANNELS (CHANNELS),
      .SEQ_LEN  (SEQ_LEN)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_command       (req_command),
      .req_hop_index     (req_hop_index),
      .req_channel_index (req_channel_index),
      .req_stall         (req_stall),
      .uid_word          (uid_word_ff),
      .out_free          (out_free),
      .rem               (rem),
      .mod_value         (mod_value),
      .mod_sel           (mod_sel),
      .rd_a              (rd_a),
      .rd_b              (rd_b),
      .tbl_req           (tbl_req),
      .rsp_ld            (rsp_ld)
   );

   hsg_modu #(
      .DIV_A (SEQ_LEN),
      .DIV_B (CHANNELS - 1)
   ) u_modu (
      .clock (clock),
      .value (mod_value),
      .sel   (mod_sel),
      .rem   (rem)
   );

   hsg_table #(
      .DEPTH (SEQ_LEN)
   ) u_table (
      .clock (clock),
      .req   (tbl_req),
      .rd_a  (rd_a),
      .rd_b  (rd_b)
   );

   always_comb begin
      if (rsp_ld.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uid_word_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            uid_word_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_ld.load) begin
         rsp_kind_ff    <= rsp_ld.kind;
         rsp_channel_ff <= rsp_ld.channel;
         rsp_freq_ff    <= rsp_ld.freq;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_freq_hz = rsp_freq_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_ld.load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response loaded over a stalled response");

   a_none_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command == CMD_NONE) |=> !rsp_ld.load)
      else $error("response produced for an unused command");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_command != CMD_NONE) |=> req_stall)
      else $error("request taken while previous request still in progress");

endmodule

`default_nettype wire

// ===== bench/hop_sequence_generator_tb.sv =====
// Self-checking bench for the hop sequence generator: table rebuild, hop lookup, frequency.
`default_nettype none

module hop_sequence_generator_tb;
   import hsg_pkg::*;

   localparam int NUM_CHANNELS = 80;
   localparam int TABLE_LEN    = 240;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 228;
   localparam int SETTLE       = 16;
   localparam int CYCLE_LIMIT  = 10_000_000;

   typedef struct {
      cmd_type           kind;
      logic [CH_W-1:0]   channel;
      logic [FREQ_W-1:0] freq;
   } hop_result_type;

   class hop_scoreboard;
      logic [CH_W-1:0]  hop_table[TABLE_LEN];
      logic [LCG_W-1:0] lcg;
      logic [UID_W-1:0] uid;
      hop_result_type   awaited[$];
      int               errors;
      int               n_regen, n_lookup, n_freq, n_ignored;

      function new();
         foreach (hop_table[i]) hop_table[i] = '0;
         lcg = '0;
         uid = '0;
         errors = 0;
         n_regen = 0;
         n_lookup = 0;
         n_freq = 0;
         n_ignored = 0;
      endfunction

      function void set_uid(input logic [UID_W-1:0] value);
         uid = value;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function logic [FREQ_W-1:0] channel_hz(input logic [CH_W-1:0] ch);
         return FREQ_W'(FREQ_BASE + {24'd0, ch} * FREQ_STEP);
      endfunction

      function void rebuild_table();
         int unsigned sync, pos, base, r, j;
         logic [CH_W-1:0] t;
         logic [31:0] next;
         sync = NUM_CHANNELS / 2 + 1;
         lcg = LCG_W'(uid ^ {24'd0, SEED_XOR});
         for (int i = 0; i < TABLE_LEN; i++) begin
            pos = i % NUM_CHANNELS;
            if (pos == 0) begin
               hop_table[i] = CH_W'(sync);
            end else if (pos == sync) begin
               hop_table[i] = '0;
            end else begin
               hop_table[i] = CH_W'(pos);
            end
         end
         for (int i = 0; i < TABLE_LEN; i++) begin
            pos = i % NUM_CHANNELS;
            if (pos != 0) begin
               base = i - pos;
               next = 32'(LCG_MUL) * 32'(lcg) + 32'(LCG_ADD);
               lcg = next[LCG_W-1:0];
               r = (32'(lcg) >> 16) % (NUM_CHANNELS - 1) + 1;
               j = base + r;
               // partner past the table end: draw consumed, no swap
               if (j < TABLE_LEN) begin
                  t = hop_table[i];
                  hop_table[i] = hop_table[j];
                  hop_table[j] = t;
               end
            end
         end
      endfunction

      function void note_request(input logic [1:0] cmd, input logic [HOP_W-1:0] hop,
                                 input logic [CH_W-1:0] chi);
         hop_result_type res;
         res.kind = cmd_type'(cmd);
         case (cmd_type'(cmd))
            CMD_REGEN: begin
               rebuild_table();
               res.channel = '0;
               res.freq = '0;
               n_regen++;
            end
            CMD_LOOKUP: begin
               res.channel = hop_table[int'(hop) % TABLE_LEN];
               res.freq = channel_hz(res.channel);
               n_lookup++;
            end
            CMD_FREQ: begin
               res.channel = chi;
               res.freq = channel_hz(chi);
               n_freq++;
            end
            default: begin
               n_ignored++;
               return;
            end
         endcase
         awaited.push_back(res);
      endfunction

      function void check_response(input logic [1:0] kind, input logic [CH_W-1:0] ch,
                                   input logic [FREQ_W-1:0] freq);
         hop_result_type res;
         if (awaited.size() == 0) begin
            $error("response with nothing outstanding: kind %0d channel %0d freq %0d",
                   kind, ch, freq);
            errors++;
            return;
         end
         res = awaited.pop_front();
         if (kind !== res.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", res.kind, kind);
            errors++;
         end
         if (ch !== res.channel) begin
            $error("channel mismatch: expected %0d, actual %0d", res.channel, ch);
            errors++;
         end
         if (freq !== res.freq) begin
            $error("freq_hz mismatch: expected %0d, actual %0d", res.freq, freq);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_command;
   logic [HOP_W-1:0]  req_hop_index;
   logic [CH_W-1:0]   req_channel_index;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_kind;
   logic [CH_W-1:0]   rsp_channel;
   logic [FREQ_W-1:0] rsp_freq_hz;
   logic              csr_we;
   logic [UID_W-1:0]  csr_wdata;

   hop_scoreboard sb = new();
   bit            idle_on = 1'b1;
   int            cycles = 0;
   int            settings = 0;

   hop_sequence_generator #(
      .CHANNELS(NUM_CHANNELS),
      .SEQ_LEN (TABLE_LEN)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_hop_index    (req_hop_index),
      .req_channel_index(req_channel_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_channel      (rsp_channel),
      .rsp_freq_hz      (rsp_freq_hz),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d outstanding", cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side: random stall after each accepted response
   initial begin
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_kind, rsp_channel, rsp_freq_hz);
            hold = idle_on ? $urandom_range(0, 6) : 0;
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            hold--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic send_request(input cmd_type cmd, input logic [HOP_W-1:0] hop,
                               input logic [CH_W-1:0] chi);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_hop_index = hop;
      req_channel_index = chi;
      do @(posedge clock); while (req_stall);
      sb.note_request(req_command, req_hop_index, req_channel_index);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // an ignored command leaves no result to wait for
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_uid(input logic [UID_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      sb.set_uid(value);
      @(negedge clock);
      csr_we = 1'b0;
      settings++;
   endtask

   function automatic cmd_type pick_command();
      int w;
      w = $urandom_range(0, 99);
      if (w < 3) return CMD_REGEN;
      if (w < 73) return CMD_LOOKUP;
      if (w < 93) return CMD_FREQ;
      return CMD_NONE;
   endfunction

   task automatic run_phase(input logic [UID_W-1:0] uid);
      int      done;
      cmd_type cmd;
      logic [HOP_W-1:0] hop;
      wait_idle();
      write_uid(uid);
      idle_on = $urandom_range(0, 3) != 0;
      send_request(CMD_REGEN, HOP_W'($urandom), CH_W'($urandom));
      done = 1;
      while (done < PHASE_ITEMS) begin
         if (done % 64 == 0) idle_on = $urandom_range(0, 3) != 0;
         cmd = pick_command();
         hop = ($urandom_range(0, 3) == 0) ? HOP_W'($urandom_range(0, 2 * TABLE_LEN))
                                            : HOP_W'($urandom);
         send_request(cmd, hop, CH_W'($urandom));
         done++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_NONE;
      req_hop_index = '0;
      req_channel_index = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // lookups before any rebuild return channel 0
      send_request(CMD_LOOKUP, 16'd0, 8'd0);
      send_request(CMD_LOOKUP, 16'hFFFF, 8'hFF);
      send_request(CMD_FREQ, 16'd0, 8'd0);
      send_request(CMD_FREQ, 16'hFFFF, 8'hFF);
      send_request(CMD_NONE, 16'hFFFF, 8'hFF);
      send_request(CMD_REGEN, 16'd0, 8'd0);
      send_request(CMD_LOOKUP, 16'd0, 8'd0);
      send_request(CMD_LOOKUP, 16'd41, 8'd0);
      send_request(CMD_LOOKUP, 16'd79, 8'd0);
      send_request(CMD_LOOKUP, 16'd80, 8'd0);
      send_request(CMD_LOOKUP, 16'd239, 8'd0);
      send_request(CMD_LOOKUP, 16'd240, 8'd0);
      send_request(CMD_LOOKUP, 16'hFFFF, 8'd0);
      send_request(CMD_FREQ, 16'd0, 8'd128);
      wait_idle();
      // seed wider than the generator
      write_uid(32'hFFFF_FFFF);
      send_request(CMD_REGEN, 16'hFFFF, 8'hFF);
      send_request(CMD_LOOKUP, 16'd1, 8'd0);
      send_request(CMD_LOOKUP, 16'd160, 8'd0);
      send_request(CMD_LOOKUP, 16'd200, 8'd0);
      send_request(CMD_LOOKUP, 16'hFFFE, 8'd0);
      wait_idle();
      // seed of zero after the xor
      write_uid(32'h0000_0003);
      send_request(CMD_REGEN, 16'd0, 8'd0);
      send_request(CMD_LOOKUP, 16'd81, 8'd0);
      send_request(CMD_LOOKUP, 16'd121, 8'd0);
      send_request(CMD_NONE, 16'd0, 8'd0);
      send_request(CMD_LOOKUP, 16'd238, 8'h55);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: run_phase(32'h8000_0003);
            1: run_phase(32'h7FFF_FFFF);
            2: run_phase(32'h0000_0000);
            3: run_phase(32'hFFFF_FFFF);
            default: run_phase($urandom);
         endcase
      end

      wait_idle();
      $display("covered %0d rebuilds, %0d lookups, %0d conversions, %0d ignored requests",
               sb.n_regen, sb.n_lookup, sb.n_freq, sb.n_ignored);
      $display("across %0d identifier settings in %0d cycles", settings + 1, cycles);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d errors, %0d responses never seen", sb.errors, sb.pending());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
src/hsg_pkg.sv
src/hsg_table.sv
src/hsg_modu.sv
src/hsg_ctrl.sv
src/hop_sequence_generator.sv
bench/hop_sequence_generator_tb.sv
